[rtl/core/tsq_pkg.sv]
// Shared types for the tone sequence queue.
// Holds the controller operation codes and the command and status structs.
// No dependencies.
package tsq_pkg;

  // One operation is applied to the datapath state per input word.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CANCEL,
    OP_DROP,
    OP_PUSH,
    OP_TICK,
    OP_POP,
    OP_STOP
  } tsq_op_e;

  typedef struct packed {
    logic    load;  // capture the input word
    logic    exec;  // apply op to the state and load the result registers
    tsq_op_e op;
  } tsq_cmd_t;

  typedef struct packed {
    logic is_request;
    logic is_cancel;
    logic full;
    logic empty;
    logic armed;
    logic expiring;  // the countdown reaches zero on this tick
  } tsq_status_t;

endpackage

[rtl/core/tsq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the tone queue storage. No dependencies.
module tsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tsq_ctrl.sv]
// Controller for the tone sequence queue: sequences each word through
// capture, execute and result hand-off. Depends on tsq_pkg.
module tsq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  tsq_pkg::tsq_status_t status_i,
  output tsq_pkg::tsq_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HOLD
  } state_e;

  state_e          state_q, state_d;
  tsq_pkg::tsq_op_e op;

  // Choose the operation from the captured word and the queue state.
  always_comb begin
    op = tsq_pkg::OP_NONE;
    if (status_i.is_request) begin
      if (status_i.is_cancel) begin
        op = tsq_pkg::OP_CANCEL;
      end else if (status_i.full) begin
        op = tsq_pkg::OP_DROP;
      end else begin
        op = tsq_pkg::OP_PUSH;
      end
    end else if (status_i.armed) begin
      if (!status_i.expiring) begin
        op = tsq_pkg::OP_TICK;
      end else if (status_i.empty) begin
        op = tsq_pkg::OP_STOP;
      end else begin
        op = tsq_pkg::OP_POP;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_HOLD;
      ST_HOLD: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_HOLD);

  assign cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.exec = (state_q == ST_EXEC);
  assign cmd_o.op   = op;

endmodule

[rtl/core/tsq_dp.sv]
// Datapath for the tone sequence queue: queue pointers and count, the
// countdown, the driven frequency and the result registers.
// Depends on tsq_pkg and tsq_ram.
module tsq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsq_pkg::tsq_cmd_t    cmd_i,
  output tsq_pkg::tsq_status_t status_o,
  input  logic                 mode_i,
  input  logic [15:0]          tone_hz_i,
  input  logic [15:0]          duration_ms_i,
  output logic [15:0]          drive_hz_o,
  output logic                 drive_changed_o,
  output logic                 timer_running_o,
  output logic [4:0]           queue_level_o,
  output logic                 dropped_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = (CW > 5) ? CW : 5;

  logic          mode_q;
  logic [15:0]   hz_q, dur_q;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   cur_hz_q, cur_hz_d, ticks_q, ticks_d;
  logic          armed_q, armed_d;
  logic [31:0]   rdata;
  logic [15:0]   pop_hz, pop_dur;
  logic [EW-1:0] level_ext;

  tsq_ram #(
    .WIDTH(32),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && (cmd_i.op == tsq_pkg::OP_PUSH)),
    .waddr_i(wr_ptr_q),
    .wdata_i({hz_q, dur_q}),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  assign pop_hz  = rdata[31:16];
  assign pop_dur = rdata[15:0];

  assign status_o.is_request = mode_q;
  assign status_o.is_cancel  = (hz_q == 16'd0) && (dur_q == 16'd0);
  assign status_o.full       = (count_q == CW'(QUEUE_DEPTH));
  assign status_o.empty      = (count_q == '0);
  assign status_o.armed      = armed_q;
  assign status_o.expiring   = (ticks_q <= 16'd1);

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    cur_hz_d = cur_hz_q;
    ticks_d  = ticks_q;
    armed_d  = armed_q;
    case (cmd_i.op)
      tsq_pkg::OP_CANCEL: begin
        rd_ptr_d = '0;
        wr_ptr_d = '0;
        count_d  = '0;
        cur_hz_d = 16'd0;
        ticks_d  = 16'd0;
        armed_d  = 1'b0;
      end
      tsq_pkg::OP_PUSH: begin
        wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
        count_d  = count_q + 1'b1;
        if (count_q == '0) begin
          ticks_d = 16'd1;
          armed_d = 1'b1;
        end
      end
      tsq_pkg::OP_TICK: ticks_d = ticks_q - 16'd1;
      tsq_pkg::OP_POP: begin
        cur_hz_d = pop_hz;
        ticks_d  = (pop_dur == 16'd0) ? 16'd1 : pop_dur;
        rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
        count_d  = count_q - 1'b1;
      end
      tsq_pkg::OP_STOP: begin
        cur_hz_d = 16'd0;
        ticks_d  = 16'd0;
        armed_d  = 1'b0;
      end
      default: ;
    endcase
  end

  assign level_ext = EW'(count_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      hz_q   <= tone_hz_i;
      dur_q  <= duration_ms_i;
    end
    if (cmd_i.exec) begin
      drive_hz_o      <= cur_hz_d;
      drive_changed_o <= (cur_hz_d != cur_hz_q);
      timer_running_o <= armed_d;
      queue_level_o   <= level_ext[4:0];
      dropped_o       <= (cmd_i.op == tsq_pkg::OP_DROP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
      cur_hz_q <= 16'd0;
      ticks_q  <= 16'd0;
      armed_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      cur_hz_q <= cur_hz_d;
      ticks_q  <= ticks_d;
      armed_q  <= armed_d;
    end
  end

endmodule

[rtl/core/tone_sequence_queue.sv]
// Tone sequence queue: top level of the buzzer tone sequencer.
// Instantiates tsq_ctrl and tsq_dp; depends on tsq_pkg.
//
// Each input word is either a one-millisecond tick (mode 0) or a beep
// request (mode 1), and each word produces exactly one result word. A
// request with zero frequency and zero duration cancels: the queue is
// flushed, the countdown stops and the buzzer is silenced. Other requests
// join a queue of QUEUE_DEPTH entries, or are dropped with the dropped flag
// set when the queue is full. A request that leaves one entry queued arms
// the countdown for one tick; on expiry the next entry is popped and its
// frequency is driven for its duration (zero counts as one tick), and an
// empty queue at expiry silences the buzzer and stops the countdown.
// Each word passes through capture, then a step that reads the queue head
// from its registered RAM and updates the state, then a hold state with
// the result word offered until it is taken; a new word is taken at the
// earliest in the cycle after the result is taken, so words never overlap.
// After reset the block is ready at once; no memory clearing is needed.
module tone_sequence_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [15:0] tone_hz_i,
  input  logic [15:0] duration_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] drive_hz_o,
  output logic        drive_changed_o,
  output logic        timer_running_o,
  output logic [4:0]  queue_level_o,
  output logic        dropped_o
);

  tsq_pkg::tsq_cmd_t    cmd;
  tsq_pkg::tsq_status_t status;

  // The controller only sequences the word and picks the operation; all
  // queue and countdown state lives in the datapath.
  tsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tsq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (mode_i),
    .tone_hz_i      (tone_hz_i),
    .duration_ms_i  (duration_ms_i),
    .drive_hz_o     (drive_hz_o),
    .drive_changed_o(drive_changed_o),
    .timer_running_o(timer_running_o),
    .queue_level_o  (queue_level_o),
    .dropped_o      (dropped_o)
  );

  // An accepted word yields its result word once the execute state has passed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##2 out_valid_o)
    else $error("result word did not follow an accepted word");

  // No new word is taken while a result is still offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result was pending");

  // With the countdown stopped the buzzer must be silent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !timer_running_o) |-> (drive_hz_o == 16'd0))
    else $error("buzzer driven with the countdown stopped");

  // A dropped request never changes the tone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |-> !drive_changed_o)
    else $error("dropped request changed the driven tone");

  // The reported level never exceeds the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((QUEUE_DEPTH > 31) || (int'(queue_level_o) <= QUEUE_DEPTH)))
    else $error("queue level beyond queue depth");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench for tone_sequence_queue: drives beep requests and millisecond ticks and
// checks every result word against a behavioural prediction of the sequencer.
// Depends on the tone_sequence_queue RTL only; needs no files or arguments.
module tb;

  localparam int  QUEUE_DEPTH  = 16;
  localparam int  STALL_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int  RANDOM_WORDS = 400;
  localparam bit  MODE_TICK    = 1'b0;
  localparam bit  MODE_REQUEST = 1'b1;

  typedef struct {
    bit        mode;
    bit [15:0] hz;
    bit [15:0] ms;
  } beep_word_t;

  typedef struct {
    logic [15:0] hz;
    logic        changed;
    logic        running;
    logic [4:0]  level;
    logic        dropped;
  } buzz_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [15:0] tone_hz = '0;
  logic [15:0] duration_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] drive_hz;
  logic        drive_changed;
  logic        timer_running;
  logic [4:0]  queue_level;
  logic        dropped;

  beep_word_t   beep_words_pending[$];
  buzz_result_t buzzer_results_due[$];
  int           total_words;
  int           words_issued = 0;
  int           failures = 0;
  int           quiet_cycles = 0;
  logic         word_taken = 1'b0;

  // Predicted sequencer state.
  logic [15:0] fifo_hz[QUEUE_DEPTH];
  logic [15:0] fifo_ms[QUEUE_DEPTH];
  int          head_idx = 0;
  int          tail_idx = 0;
  int          fifo_fill = 0;
  logic [15:0] sounding_hz = '0;
  logic [15:0] ms_left = '0;
  logic        countdown_on = 1'b0;

  tone_sequence_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .tone_hz_i      (tone_hz),
    .duration_ms_i  (duration_ms),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .drive_hz_o     (drive_hz),
    .drive_changed_o(drive_changed),
    .timer_running_o(timer_running),
    .queue_level_o  (queue_level),
    .dropped_o      (dropped)
  );

  always #5 clk_i = ~clk_i;

  // Applies one accepted word to the predicted state and returns the result word
  // that the sequencer should offer for it.
  task automatic predict_buzzer_result(input beep_word_t w, output buzz_result_t r);
    logic [15:0] prev_hz;
    logic        drop;
    prev_hz = sounding_hz;
    drop = 1'b0;
    if (w.mode == MODE_REQUEST) begin
      if (w.hz == 0 && w.ms == 0) begin
        // A cancel flushes everything and silences the buzzer.
        fifo_fill = 0;
        head_idx = 0;
        tail_idx = 0;
        countdown_on = 1'b0;
        ms_left = '0;
        sounding_hz = '0;
      end else if (fifo_fill >= QUEUE_DEPTH) begin
        drop = 1'b1;
      end else begin
        fifo_hz[tail_idx] = w.hz;
        fifo_ms[tail_idx] = w.ms;
        tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
        fifo_fill++;
        // The first queued entry restarts the countdown, even mid-tone.
        if (fifo_fill == 1) begin
          ms_left = 16'd1;
          countdown_on = 1'b1;
        end
      end
    end else if (countdown_on) begin
      if (ms_left != 0) ms_left--;
      if (ms_left == 0) begin
        if (fifo_fill == 0) begin
          sounding_hz = '0;
          countdown_on = 1'b0;
        end else begin
          sounding_hz = fifo_hz[head_idx];
          ms_left = fifo_ms[head_idx];
          if (ms_left == 0) ms_left = 16'd1;
          head_idx = (head_idx + 1) % QUEUE_DEPTH;
          fifo_fill--;
        end
      end
    end
    r.hz = sounding_hz;
    r.changed = (sounding_hz != prev_hz);
    r.running = countdown_on;
    r.level = fifo_fill[4:0];
    r.dropped = drop;
  endtask

  task automatic queue_word(input bit m, input bit [15:0] hz, input bit [15:0] ms);
    beep_word_t w;
    w.mode = m;
    w.hz = hz;
    w.ms = ms;
    beep_words_pending.push_back(w);
  endtask

  // Driver: inputs move at the falling edge. The idling mix changes with progress:
  // light sender gaps with heavy receiver stalls first, then the reverse, then full
  // speed.
  always @(negedge clk_i) begin
    int         send_pct;
    int         recv_pct;
    beep_word_t w;
    if (words_issued < total_words / 3) begin
      send_pct = 9;
      recv_pct = 49;
    end else if (words_issued < 2 * total_words / 3) begin
      send_pct = 49;
      recv_pct = 9;
    end else begin
      send_pct = 0;
      recv_pct = 0;
    end
    if (rst_ni) begin
      out_stall <= ($urandom_range(99) < recv_pct);
      // A word on offer is held until taken; only then is the next one chosen.
      if (!in_valid || word_taken) begin
        if (beep_words_pending.size() != 0 && $urandom_range(99) >= send_pct) begin
          w = beep_words_pending.pop_front();
          in_valid <= 1'b1;
          mode <= w.mode;
          tone_hz <= w.hz;
          duration_ms <= w.ms;
          words_issued <= words_issued + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: both handshakes are sampled at the rising edge. The prediction is made
  // when a word is accepted, and each result word is checked against the oldest one.
  always @(posedge clk_i) begin
    beep_word_t   w;
    buzz_result_t want;
    if (rst_ni) begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        w.mode = mode;
        w.hz = tone_hz;
        w.ms = duration_ms;
        predict_buzzer_result(w, want);
        buzzer_results_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (buzzer_results_due.size() == 0) begin
          $error("result word with nothing expected: drive_hz %0d", drive_hz);
          failures++;
        end else begin
          want = buzzer_results_due.pop_front();
          if (drive_hz !== want.hz) begin
            $error("drive_hz: expected %0d, got %0d", want.hz, drive_hz);
            failures++;
          end
          if (drive_changed !== want.changed) begin
            $error("drive_changed: expected %0b, got %0b", want.changed, drive_changed);
            failures++;
          end
          if (timer_running !== want.running) begin
            $error("timer_running: expected %0b, got %0b", want.running, timer_running);
            failures++;
          end
          if (queue_level !== want.level) begin
            $error("queue_level: expected %0d, got %0d", want.level, queue_level);
            failures++;
          end
          if (dropped !== want.dropped) begin
            $error("dropped: expected %0b, got %0b", want.dropped, dropped);
            failures++;
          end
        end
      end
    end
  end

  // Watchdog: the block should never sit for long with no word moving.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tone_sequence_queue: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int random_count;
    int burst;
    int k;

    // Directed opening: idle tick, cancel while silent, zero duration, playback
    // running out, a request re-arming the countdown while a tone sounds, and a
    // cancel that silences a playing tone.
    queue_word(MODE_TICK, 16'h0000, 16'h0000);
    queue_word(MODE_REQUEST, 16'h0000, 16'h0000);
    queue_word(MODE_REQUEST, 16'hFFFF, 16'h0000);
    queue_word(MODE_TICK, 16'hFFFF, 16'hFFFF);
    queue_word(MODE_TICK, 16'h0000, 16'h0000);
    queue_word(MODE_REQUEST, 16'h0001, 16'h0002);
    queue_word(MODE_TICK, 16'h0000, 16'h0000);
    queue_word(MODE_REQUEST, 16'h8000, 16'hFFFF);
    queue_word(MODE_TICK, 16'h0000, 16'h0000);
    queue_word(MODE_REQUEST, 16'h0000, 16'h0000);
    // Fill the queue to the brim (zero frequency with a duration is a real entry),
    // then one more request, which must be dropped.
    queue_word(MODE_REQUEST, 16'h0000, 16'h0005);
    for (k = 1; k < QUEUE_DEPTH; k++) begin
      queue_word(MODE_REQUEST, 16'(k * 4099), (k % 2) ? 16'hFFFF : 16'h0001);
    end
    queue_word(MODE_REQUEST, 16'hFFFF, 16'hFFFF);

    // Random part: bursts of requests followed by runs of ticks, so the queue fills,
    // drains and overflows. Mostly short tones; the odd long one is cut off by a
    // cancel at the start of a later burst.
    random_count = 0;
    while (random_count < RANDOM_WORDS) begin
      if ($urandom_range(99) < 20) begin
        queue_word(MODE_REQUEST, 16'h0000, 16'h0000);
        random_count++;
      end
      burst = $urandom_range(1, 20);
      for (k = 0; k < burst; k++) begin
        queue_word(MODE_REQUEST,
                   ($urandom_range(99) < 10) ? 16'h0000 : 16'($urandom),
                   ($urandom_range(99) < 85) ? 16'($urandom_range(0, 3)) : 16'($urandom));
        random_count++;
      end
      burst = $urandom_range(1, 40);
      for (k = 0; k < burst; k++) begin
        queue_word(MODE_TICK, 16'($urandom), 16'($urandom));
        random_count++;
      end
    end
    total_words = beep_words_pending.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (beep_words_pending.size() != 0 || in_valid || buzzer_results_due.size() != 0) begin
      @(posedge clk_i);
    end
    // Wait on so that any spurious result word is still caught.
    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("tone_sequence_queue: match");
    end else begin
      $display("tone_sequence_queue: mismatch");
    end
    $finish;
  end

endmodule
